// ----- rtl/mtu_pkg.sv -----
// ----------------------------------------------------------------------------
// mtu_pkg: shared types and codes of the 4x4 transform unit
// Holds the mode codes, the operation codes of the internal queue and the
// layout of one queued word.
// ----------------------------------------------------------------------------
package mtu_pkg;

    // Mode field codes on the input channel.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_XFORM   = 2'd1;
    localparam logic [1:0] MODE_COMPOSE = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // Right-hand column number that commits a composition.
    localparam logic [1:0] LAST_COLUMN = 2'd3;

    // Operation carried through the queue to the datapath.
    typedef enum logic [3:0] {
        OP_LOAD    = 4'b0001,
        OP_XFORM   = 4'b0010,
        OP_COMPOSE = 4'b0100,
        OP_COMMIT  = 4'b1000
    } mtu_op_t;

    // One classified word. vec[0] is x, vec[3] is w. elem_value is already
    // clamped to the storage range and sign-extended to 32 bits.
    typedef struct packed {
        mtu_op_t            op;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic [1:0]         column_index;
        logic [3:0][31:0]   vec;
    } mtu_item_t;

endpackage

// ----- rtl/mtu_front.sv -----
// ----------------------------------------------------------------------------
// mtu_front: input side of the transform unit
// Accepts input words, drops the unused mode, clamps load values and turns
// the mode and column number into an operation code for the queue.
// ----------------------------------------------------------------------------
module mtu_front #(
    parameter int SW = 32
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [3:0]          s_elem_index,
    input  logic signed [31:0]  s_elem_value,
    input  logic [1:0]          s_column_index,
    input  logic signed [31:0]  s_vec_x,
    input  logic signed [31:0]  s_vec_y,
    input  logic signed [31:0]  s_vec_z,
    input  logic signed [31:0]  s_vec_w,
    input  logic                q_full,
    output logic                q_push,
    output mtu_pkg::mtu_item_t  q_item
);
    import mtu_pkg::*;

    logic              keep;
    logic              fits;
    logic [SW-1:0]     clamped;
    logic [31-SW+1:0]  top_bits;

    // The value fits the storage range when every bit from the sign
    // position of that range upward agrees.
    assign top_bits = s_elem_value[31:SW-1];
    assign fits     = (&top_bits) | ~(|top_bits);

    always_comb begin
        if (fits) begin
            clamped = s_elem_value[SW-1:0];
        end else if (s_elem_value[31]) begin
            clamped = {1'b1, {(SW-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(SW-1){1'b1}}};
        end
    end

    always_comb begin
        keep       = 1'b1;
        q_item.op  = OP_XFORM;
        unique case (s_mode)
            MODE_LOAD:    q_item.op = OP_LOAD;
            MODE_XFORM:   q_item.op = OP_XFORM;
            MODE_COMPOSE: q_item.op = (s_column_index == LAST_COLUMN) ? OP_COMMIT
                                                                      : OP_COMPOSE;
            MODE_NONE:    keep = 1'b0;
            default:      keep = 1'b0;
        endcase
        q_item.elem_index   = s_elem_index;
        q_item.elem_value   = 32'($signed(clamped));
        q_item.column_index = s_column_index;
        q_item.vec[0]       = s_vec_x;
        q_item.vec[1]       = s_vec_y;
        q_item.vec[2]       = s_vec_z;
        q_item.vec[3]       = s_vec_w;
    end

    // Words of the unused mode are taken and dropped here.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

endmodule

// ----- rtl/mtu_queue.sv -----
// ----------------------------------------------------------------------------
// mtu_queue: decoupling queue of the transform unit
// A small first-in first-out queue of classified words between the input
// side and the datapath, with the head word visible combinationally.
// ----------------------------------------------------------------------------
module mtu_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_i,
    input  mtu_pkg::mtu_item_t  item_i,
    output logic                full_o,
    input  logic                pop_i,
    output logic                empty_o,
    output mtu_pkg::mtu_item_t  head_o
);
    import mtu_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mtu_item_t       store_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full_o  = (count_reg == CW'(DEPTH));
    assign empty_o = (count_reg == '0);
    assign head_o  = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop_i) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({push_i, pop_i})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            2'b11:   count_next = count_reg;
            2'b00:   count_next = count_reg;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            store_reg[wr_ptr_reg] <= item_i;
        end
    end

endmodule

// ----- rtl/mtu_back.sv -----
// ----------------------------------------------------------------------------
// mtu_back: datapath of the transform unit
// Holds the current and shadow matrices, multiplies the matrix by the head
// vector in sixteen parallel lanes, adds and clamps over two more stages,
// and drives the result register.
// ----------------------------------------------------------------------------
module mtu_back #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  mtu_pkg::mtu_item_t  head_i,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic signed [31:0]  m_out_w,
    output logic                m_saturated
);
    import mtu_pkg::*;

    // Matrix entries must hold the clamped range and the reset diagonal.
    localparam int MW   = (SW > FRAC_BITS + 2) ? SW : FRAC_BITS + 2;
    localparam int PW   = MW + 32;
    localparam int SUMW = PW + 2;
    localparam logic signed [MW-1:0] ONE = MW'(1) << FRAC_BITS;

    logic signed [MW-1:0]   matrix_reg [16];
    logic signed [MW-1:0]   pending_reg [3][4];

    logic signed [31:0]     hv [4];
    logic signed [PW-1:0]   prod_next [16];
    logic signed [PW-1:0]   prod_reg [16];
    logic signed [PW:0]     pair_next [8];
    logic signed [PW:0]     pair_reg [8];
    logic signed [SUMW-1:0] sum [4];
    logic signed [SW-1:0]   res [4];
    logic [3:0]             clip;

    logic                   s1_valid_reg, s2_valid_reg, m_valid_reg;
    mtu_op_t                s1_op_reg, s2_op_reg;
    logic [1:0]             s1_col_reg, s2_col_reg;
    logic signed [31:0]     out_reg [4];
    logic                   sat_reg;

    logic                   adv;
    logic                   hazard;

    // The whole pipeline moves together and stops while a result waits.
    assign adv    = !m_valid_reg || m_ready;
    // A commit rewrites the matrix from the last stage, so nothing may read
    // the matrix until it has landed.
    assign hazard = (s1_valid_reg && s1_op_reg == OP_COMMIT)
                 || (s2_valid_reg && s2_op_reg == OP_COMMIT);
    assign pop    = adv && head_valid && !hazard;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            hv[k] = head_i.vec[k];
        end
        for (int k = 0; k < 4; k++) begin
            for (int r = 0; r < 4; r++) begin
                prod_next[r + 4 * k] = (matrix_reg[r + 4 * k] * hv[k]) >>> FRAC_BITS;
            end
        end
        for (int r = 0; r < 4; r++) begin
            pair_next[2 * r]     = prod_reg[r]     + prod_reg[r + 4];
            pair_next[2 * r + 1] = prod_reg[r + 8] + prod_reg[r + 12];
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum[r]  = pair_reg[2 * r] + pair_reg[2 * r + 1];
            clip[r] = !((&sum[r][SUMW-1:SW-1]) || !(|sum[r][SUMW-1:SW-1]));
            if (!clip[r]) begin
                res[r] = sum[r][SW-1:0];
            end else if (sum[r][SUMW-1]) begin
                res[r] = {1'b1, {(SW-1){1'b0}}};
            end else begin
                res[r] = {1'b0, {(SW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    matrix_reg[r + 4 * c] <= (r == c) ? ONE : '0;
                end
            end
        end else begin
            if (adv && s2_valid_reg && s2_op_reg == OP_COMMIT) begin
                for (int c = 0; c < 3; c++) begin
                    for (int r = 0; r < 4; r++) begin
                        matrix_reg[r + 4 * c] <= pending_reg[c][r];
                    end
                end
                for (int r = 0; r < 4; r++) begin
                    matrix_reg[12 + r] <= MW'(res[r]);
                end
            end
            if (pop && head_i.op == OP_LOAD) begin
                matrix_reg[head_i.elem_index] <= MW'(head_i.elem_value);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_valid_reg && s2_op_reg == OP_COMPOSE) begin
            for (int r = 0; r < 4; r++) begin
                pending_reg[s2_col_reg][r] <= MW'(res[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= pop && head_i.op != OP_LOAD;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg && s2_op_reg == OP_XFORM;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg  <= head_i.op;
            s1_col_reg <= head_i.column_index;
            prod_reg   <= prod_next;
            s2_op_reg  <= s1_op_reg;
            s2_col_reg <= s1_col_reg;
            pair_reg   <= pair_next;
            if (s2_valid_reg && s2_op_reg == OP_XFORM) begin
                for (int r = 0; r < 4; r++) begin
                    out_reg[r] <= 32'(res[r]);
                end
                sat_reg <= |clip;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = out_reg[0];
    assign m_out_y     = out_reg[1];
    assign m_out_z     = out_reg[2];
    assign m_out_w     = out_reg[3];
    assign m_saturated = sat_reg;

`ifndef ASSERT_OFF
    a_commit_blocks_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && s2_op_reg == OP_COMMIT) |-> !pop)
        else $error("word issued while a commit was still in flight");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved while the result register was stalled");

    a_load_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_i.op == OP_LOAD) |=>
        (matrix_reg[$past(head_i.elem_index)] == MW'($past(head_i.elem_value))))
        else $error("loaded element did not reach the matrix");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s2_valid_reg && s2_op_reg == OP_XFORM))
        else $error("result shown without a transform behind it");
`endif

endmodule

// ----- rtl/mat4_transform_unit_top.sv -----
// ----------------------------------------------------------------------------
// mat4_transform_unit_top: 4x4 fixed-point transform matrix engine
// Keeps a column-major 4x4 matrix, loads it element by element, composes it
// with a right-hand matrix column by column, and transforms 4-vectors.
// ----------------------------------------------------------------------------
// Usage: input words arrive on the s_ channel (valid/ready). Mode 0 writes one
// matrix element, mode 1 transforms a vector, mode 2 delivers one column of a
// right-hand matrix, and column 3 replaces the matrix with the product. Mode 3
// words are taken and dropped. Only mode 1 words produce a result word on the
// m_ channel; the saturated bit marks a clamped component.
// Path: a transform word passes through the queue, the multiply lane stage,
// the pair-sum stage, then add, clamp and the result register.
// Throughput: one word per cycle in every mode while no result waits on
// m_ready. A commit column holds back the word after it until the new matrix
// has been written from the last stage.
// Reset: the matrix returns to identity and the queue empties. The shadow
// columns are not cleared; compose columns 0 to 2 before the commit.
// Stall: while a result waits on m_ready the datapath holds; the input side
// keeps taking words into the queue until it is full, then drops s_ready.
// ----------------------------------------------------------------------------
module mat4_transform_unit_top #(
    parameter int FRAC_BITS   = 16,
    parameter int WORD_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [3:0]          s_elem_index,
    input  logic signed [31:0]  s_elem_value,
    input  logic [1:0]          s_column_index,
    input  logic signed [31:0]  s_vec_x,
    input  logic signed [31:0]  s_vec_y,
    input  logic signed [31:0]  s_vec_z,
    input  logic signed [31:0]  s_vec_w,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic signed [31:0]  m_out_w,
    output logic                m_saturated
);
    import mtu_pkg::*;

    // Sums are clamped to at most 32 bits, the width of the result ports.
    localparam int SW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;

    logic       q_push;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    mtu_item_t  q_item;
    mtu_item_t  q_head;

    mtu_front #(
        .SW (SW)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_elem_index   (s_elem_index),
        .s_elem_value   (s_elem_value),
        .s_column_index (s_column_index),
        .s_vec_x        (s_vec_x),
        .s_vec_y        (s_vec_y),
        .s_vec_z        (s_vec_z),
        .s_vec_w        (s_vec_w),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_item)
    );

    mtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (q_push),
        .item_i  (q_item),
        .full_o  (q_full),
        .pop_i   (q_pop),
        .empty_o (q_empty),
        .head_o  (q_head)
    );

    mtu_back #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (!q_empty),
        .head_i      (q_head),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_z     (m_out_z),
        .m_out_w     (m_out_w),
        .m_saturated (m_saturated)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4x4 fixed-point transform unit
// Drives load, transform, compose and unused-mode words, predicts each
// transform result from the local matrix copy or a typed plan row, and
// checks every result word in order under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import mtu_pkg::*;

    // Signed Q16.16 value as it travels on the ports.
    typedef logic signed [31:0] q16_t;

    localparam int   FRAC            = 16;
    localparam q16_t Q_ONE           = 32'sh0001_0000;
    localparam q16_t Q_MAX           = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN           = 32'sh8000_0000;
    localparam int   RANDOM_WORDS    = 1100;
    localparam int   HOLD_OFF_CYCLES = 64;
    localparam int   DRAIN_CYCLES    = 8;
    localparam int   QUIET_LIMIT     = 2000;

    // One input word, one field per port.
    typedef struct {
        logic [1:0] mode;
        logic [3:0] elem_index;
        q16_t       elem_value;
        logic [1:0] column_index;
        q16_t       vec [4];
    } xf_word_t;

    // One result word: x, y, z, w and the clamp flag.
    typedef struct {
        q16_t out [4];
        logic sat;
    } xf_result_t;

    // A row of the directed plan. When "typed" is set, the expected result is
    // written into the row by hand instead of taken from the predictor.
    typedef struct {
        xf_word_t   w;
        bit         typed;
        xf_result_t want;
    } plan_row_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode         = MODE_NONE;
    logic [3:0] s_elem_index   = '0;
    q16_t       s_elem_value   = '0;
    logic [1:0] s_column_index = '0;
    q16_t       s_vec_x        = '0;
    q16_t       s_vec_y        = '0;
    q16_t       s_vec_z        = '0;
    q16_t       s_vec_w        = '0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    q16_t       m_out_x;
    q16_t       m_out_y;
    q16_t       m_out_z;
    q16_t       m_out_w;
    logic       m_saturated;

    // Local copy of the block's state. The matrix is column-major: element
    // r + 4*c is row r, column c. The shadow holds product columns 0 to 2 of
    // a composition in progress.
    q16_t       xf_matrix [16];
    q16_t       xf_shadow [12];
    logic [2:0] shadow_cols_seen = '0;

    xf_result_t expected_products [$];
    plan_row_t  plan [$];
    xf_result_t unused_result;

    int  error_count   = 0;
    int  words_sent    = 0;
    int  quiet_cycles  = 0;
    bit  no_idle       = 1'b0;
    bit  hold_off_req  = 1'b0;
    bit  hold_off_done = 1'b0;

    always #5 aclk = ~aclk;

    mat4_transform_unit_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_elem_index   (s_elem_index),
        .s_elem_value   (s_elem_value),
        .s_column_index (s_column_index),
        .s_vec_x        (s_vec_x),
        .s_vec_y        (s_vec_y),
        .s_vec_z        (s_vec_z),
        .s_vec_w        (s_vec_w),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_z        (m_out_z),
        .m_out_w        (m_out_w),
        .m_saturated    (m_saturated)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Current matrix times a vector. Each product is exact, then shifted
    // right arithmetically, which rounds toward minus infinity. The sum of the
    // four shifted products is exact in 64 bits and is clamped to 32 bits.
    function automatic xf_result_t matrix_times(input q16_t v [4]);
        xf_result_t r;
        longint     acc;
        int         row;
        int         k;
        r.sat = 1'b0;
        for (row = 0; row < 4; row++) begin
            acc = 0;
            for (k = 0; k < 4; k++) begin
                acc += (longint'(xf_matrix[row + 4 * k]) * longint'(v[k])) >>> FRAC;
            end
            if (acc > longint'(Q_MAX)) begin
                r.out[row] = Q_MAX;
                r.sat      = 1'b1;
            end else if (acc < longint'(Q_MIN)) begin
                r.out[row] = Q_MIN;
                r.sat      = 1'b1;
            end else begin
                r.out[row] = q16_t'(acc);
            end
        end
        return r;
    endfunction

    // Applies one accepted word to the local state. Returns 1 when the word
    // produces a result, which is then left in r.
    function automatic bit step_model(input xf_word_t w, output xf_result_t r);
        xf_result_t p;
        int         i;
        r = '{default: '0};
        case (w.mode)
            MODE_LOAD: begin
                // A 32-bit value is always inside the storage range.
                xf_matrix[w.elem_index] = w.elem_value;
                return 1'b0;
            end
            MODE_XFORM: begin
                r = matrix_times(w.vec);
                return 1'b1;
            end
            MODE_COMPOSE: begin
                // Clamping here is silent; the flag is dropped.
                p = matrix_times(w.vec);
                if (w.column_index != LAST_COLUMN) begin
                    for (i = 0; i < 4; i++) begin
                        xf_shadow[4 * w.column_index + i] = p.out[i];
                    end
                    shadow_cols_seen[w.column_index] = 1'b1;
                end else begin
                    for (i = 0; i < 12; i++) begin
                        xf_matrix[i] = xf_shadow[i];
                    end
                    for (i = 0; i < 4; i++) begin
                        xf_matrix[12 + i] = p.out[i];
                    end
                end
                return 1'b0;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random Q16.16 value. Tame values stay within +/-2.0 most of the time so
    // that compositions keep the matrix in a useful range; the rest is a mix
    // of small values, full-width random bits, up to 16 LSBs and extremes.
    function automatic q16_t rand_q16(input bit tame);
        q16_t v;
        int   pick;
        pick = $urandom_range(0, 9);
        if (tame && pick < 8) begin
            v = $urandom_range(0, 32'h0004_0000);
            return v - 32'sh0002_0000;
        end
        case (pick)
            0, 1, 2, 3: begin
                v = $urandom_range(0, 32'h0008_0000);
                return v - 32'sh0004_0000;
            end
            7: begin
                case ($urandom_range(0, 4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            8: begin
                v = $urandom_range(0, 32);
                return v - 16;
            end
            default: begin
                v = $urandom;
                return v;
            end
        endcase
    endfunction

    // Builds a word of the given mode and column; fields the mode does not
    // use are filled at random so that every port bit toggles.
    function automatic xf_word_t make_word(input logic [1:0] mode,
                                           input logic [1:0] column,
                                           input bit tame);
        xf_word_t w;
        int       i;
        w.mode         = mode;
        w.elem_index   = 4'($urandom_range(0, 15));
        w.elem_value   = rand_q16(tame);
        w.column_index = column;
        for (i = 0; i < 4; i++) begin
            w.vec[i] = rand_q16(tame);
        end
        return w;
    endfunction

    task automatic add_row(input logic [1:0] mode, input logic [3:0] idx,
                           input q16_t value, input logic [1:0] column,
                           input q16_t x, input q16_t y, input q16_t z, input q16_t w,
                           input bit typed,
                           input q16_t ex, input q16_t ey, input q16_t ez, input q16_t ew,
                           input logic esat);
        plan_row_t row;
        row.w.mode         = mode;
        row.w.elem_index   = idx;
        row.w.elem_value   = value;
        row.w.column_index = column;
        row.w.vec          = '{x, y, z, w};
        row.typed          = typed;
        row.want.out       = '{ex, ey, ez, ew};
        row.want.sat       = esat;
        plan.push_back(row);
    endtask

    // Offers one word and waits until it is accepted. A short gap may come
    // first. The valid line is lowered only in a gap, so a word that follows
    // straight after the previous one keeps valid high through the edge.
    task automatic send_word(input xf_word_t w, input bit typed, input xf_result_t want);
        xf_result_t predicted;
        if (!no_idle && $urandom_range(0, 99) < 5) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= w.mode;
        s_elem_index   <= w.elem_index;
        s_elem_value   <= w.elem_value;
        s_column_index <= w.column_index;
        s_vec_x        <= w.vec[0];
        s_vec_y        <= w.vec[1];
        s_vec_z        <= w.vec[2];
        s_vec_w        <= w.vec[3];
        do @(posedge aclk); while (!s_ready);
        if (step_model(w, predicted)) begin
            expected_products.push_back(typed ? want : predicted);
        end
        if (w.mode != MODE_NONE) begin
            words_sent++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, directed plan, then the random stream.
    // ------------------------------------------------------------------
    initial begin : sender
        int         i;
        int         kind;
        int         ncols;
        int         c;
        logic [1:0] column;
        bit         drained;

        // The local matrix starts as identity, just like the block after
        // reset. The shadow is never read before all three slots are written.
        for (i = 0; i < 16; i++) begin
            xf_matrix[i] = (i % 5 == 0) ? Q_ONE : '0;
        end
        for (i = 0; i < 12; i++) begin
            xf_shadow[i] = '0;
        end
        unused_result = '{default: '0};
        drained = 1'b0;

        // Directed plan. Rows that carry a typed result can be read straight
        // off the arithmetic: identity passes a vector through unchanged,
        // huge products clamp, and the shift rounds toward minus infinity.
        // Identity after reset, including both extremes.
        add_row(MODE_XFORM, 0, 0, 0, Q_ONE, -Q_ONE, Q_MAX, Q_MIN,
                1, Q_ONE, -Q_ONE, Q_MAX, Q_MIN, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1'b0);
        // The unused mode must leave the matrix alone and produce nothing,
        // even with a commit column and extreme values on the ports.
        add_row(MODE_NONE, 15, Q_MIN, LAST_COLUMN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, 1, -1, 2, -2, 1, 1, -1, 2, -2, 1'b0);
        // Largest element times largest component clamps high, and low for
        // the most negative component; the flag goes up.
        add_row(MODE_LOAD, 0, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_LOAD, 1, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, Q_MAX, Q_MAX, 0, 0,
                1, Q_MAX, Q_MAX, 0, 0, 1'b1);
        add_row(MODE_XFORM, 0, 0, 0, Q_MIN, 0, 0, 0, 1, Q_MIN, Q_MIN, 0, 0, 1'b1);
        // One LSB times minus one LSB floors to -1; times plus one LSB to 0.
        add_row(MODE_LOAD, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, -1, 0, 0, 0, 1, -1, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1'b0);
        // Back to identity, then a translation and an extreme corner element.
        add_row(MODE_LOAD, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_LOAD, 15, Q_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_LOAD, 12, 32'sh0002_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE,
                0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_LOAD, 15, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        // Composition with the columns out of order; column 2 clamps silently.
        add_row(MODE_COMPOSE, 0, 0, 1, 0, 2 * Q_ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_COMPOSE, 0, 0, 0, 32'sh0000_8000, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_COMPOSE, 0, 0, 2, 0, 0, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_COMPOSE, 0, 0, LAST_COLUMN, 3 * Q_ONE, -Q_ONE, 0, Q_ONE,
                0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 1'b0);
        // A lone commit column reuses whatever the shadow still holds.
        add_row(MODE_COMPOSE, 0, 0, LAST_COLUMN, Q_ONE, Q_ONE, -Q_ONE, 2 * Q_ONE,
                0, 0, 0, 0, 0, 1'b0);
        add_row(MODE_XFORM, 0, 0, 0, -Q_ONE, 3, Q_MIN, 7, 0, 0, 0, 0, 0, 1'b0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            send_word(plan[i].w, plan[i].typed, plan[i].want);
        end

        // Random stream. Most of it is transforms, loads and complete
        // compositions with random content; the rest is stray columns,
        // abandoned compositions and words of the unused mode.
        while (words_sent < RANDOM_WORDS) begin
            // Ask the receiver for one long hold-off while words keep coming,
            // so that the internal queue fills and the input side stalls.
            if (!hold_off_req && words_sent >= 300) begin
                hold_off_req = 1'b1;
            end
            // Once, stop sending until every outstanding result is back.
            if (!drained && words_sent >= 650) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_products.size() != 0);
                drained = 1'b1;
            end
            no_idle = (words_sent >= 800 && words_sent < 1000);

            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                send_word(make_word(MODE_XFORM, 2'($urandom_range(0, 3)), 1'b0),
                          1'b0, unused_result);
            end else if (kind < 60) begin
                send_word(make_word(MODE_LOAD, 2'($urandom_range(0, 3)), 1'b1),
                          1'b0, unused_result);
            end else if (kind < 85) begin
                // Columns 0 to 3 in order, sometimes with transforms between
                // them and sometimes cut short before the commit.
                ncols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4;
                for (c = 0; c < ncols; c++) begin
                    send_word(make_word(MODE_COMPOSE, 2'(c), 1'b1), 1'b0, unused_result);
                    if ($urandom_range(0, 3) == 0) begin
                        send_word(make_word(MODE_XFORM, 2'($urandom_range(0, 3)), 1'b0),
                                  1'b0, unused_result);
                    end
                end
            end else if (kind < 95) begin
                // A stray column. A commit is only allowed once every shadow
                // slot has been written since reset.
                column = 2'($urandom_range(0, 3));
                if (column == LAST_COLUMN && shadow_cols_seen != 3'b111) begin
                    column = 2'd0;
                end
                send_word(make_word(MODE_COMPOSE, column, 1'b1), 1'b0, unused_result);
            end else begin
                send_word(make_word(MODE_NONE, 2'($urandom_range(0, 3)), 1'b0),
                          1'b0, unused_result);
            end
        end

        // All words are in. Wait for the last results, then let the pipeline
        // drain in case a stray result shows up.
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_products.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold-off on request, and no
    // idling while the sender runs its quiet stretch.
    // ------------------------------------------------------------------
    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready      <= 1'b0;
                hold_off_done = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted result word is compared field by field
    // with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        xf_result_t want;
        q16_t       got [4];
        int         i;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_x, m_out_y, m_out_z, m_out_w};
            if (expected_products.size() == 0) begin
                report_mismatch("result word arrived with nothing outstanding");
            end else begin
                want = expected_products.pop_front();
                for (i = 0; i < 4; i++) begin
                    if (got[i] !== want.out[i]) begin
                        report_mismatch($sformatf("component %0d is %h, predicted %h",
                                                  i, got[i], want.out[i]));
                    end
                end
                if (m_saturated !== want.sat) begin
                    report_mismatch($sformatf("saturated is %b, predicted %b",
                                              m_saturated, want.sat));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a long run of cycles with no word moving on either channel
    // means the block has hung.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
rtl/mtu_pkg.sv
rtl/mtu_front.sv
rtl/mtu_queue.sv
rtl/mtu_back.sv
rtl/mat4_transform_unit_top.sv
verif/tb_top.sv
